>>> rtl/cht_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash table package
// Sizes, codes and shared types for the chained hash table engine.
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int BUCKETS     = 256;
    localparam int NODES       = 1024;
    localparam int HANDLE_BITS = 32;
    localparam int KEY_W       = 64;
    localparam int BKT_W       = $clog2(BUCKETS);
    localparam int IDX_W       = $clog2(NODES);
    localparam int LINK_W      = IDX_W + 1;
    localparam int CNT_W       = 11;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(NODES);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_NODE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                   we_full;
        logic                   we_link;
        logic [IDX_W-1:0]       waddr;
        logic [KEY_W-1:0]       wkey;
        logic [HANDLE_BITS-1:0] whandle;
        logic [LINK_W-1:0]      wlink;
    } node_wr_t;

endpackage

>>> rtl/cht_node_store.sv
// ----------------------------------------------------------------------------
// Node store
// Key, handle and link memories of the node pool, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module cht_node_store
    import cht_pkg::*;
(
    input  logic                   clk,
    input  node_wr_t               wr,
    input  logic [IDX_W-1:0]       raddr,
    output logic [KEY_W-1:0]       rkey,
    output logic [HANDLE_BITS-1:0] rhandle,
    output logic [LINK_W-1:0]      rlink
);

    logic [KEY_W-1:0]       key_mem    [NODES];
    logic [HANDLE_BITS-1:0] handle_mem [NODES];
    logic [LINK_W-1:0]      link_mem   [NODES];

    always_ff @(posedge clk)
    begin
        if (wr.we_full)
        begin
            key_mem[wr.waddr]    <= wr.wkey;
            handle_mem[wr.waddr] <= wr.whandle;
        end
        if (wr.we_full || wr.we_link)
        begin
            link_mem[wr.waddr] <= wr.wlink;
        end
        rkey    <= key_mem[raddr];
        rhandle <= handle_mem[raddr];
        rlink   <= link_mem[raddr];
    end

endmodule

>>> rtl/chained_hash_table_engine_top.sv
// ----------------------------------------------------------------------------
// Chained hash table engine
// Hash table on a 64-bit key with chained buckets over a shared node pool.
// ----------------------------------------------------------------------------
// Each word starts with a read of its bucket head, then walks its chain one
// node at a time through the single read port of the node store (a find
// stops at the first match, an insert and a delete walk the whole chain),
// then hands over the result before the next word is taken. No clearing
// pass is needed after reset.
module chained_hash_table_engine_top
    import cht_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             kind,
    input  logic [KEY_W-1:0]       order_key,
    input  logic [HANDLE_BITS-1:0] data_handle,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic [HANDLE_BITS-1:0] found_handle,
    output logic [CNT_W-1:0]       removed_count,
    output logic [CNT_W-1:0]       entry_total
);

    state_t state_reg, state_next;

    logic [1:0]             kind_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [LINK_W-1:0]      cur_reg, cur_next;
    logic [LINK_W-1:0]      prev_reg, prev_next;
    logic [IDX_W-1:0]       new_reg, new_next;
    logic [LINK_W-1:0]      fresh_reg, fresh_next;
    logic [LINK_W-1:0]      stack_cnt_reg, stack_cnt_next;
    logic [CNT_W-1:0]       entry_reg, entry_next;
    logic [CNT_W-1:0]       removed_reg, removed_next;
    logic [1:0]             status_reg, status_next;
    logic [HANDLE_BITS-1:0] found_reg, found_next;

    logic [LINK_W-1:0] head_mem [BUCKETS];
    logic [BUCKETS-1:0] head_valid_reg;
    logic [LINK_W-1:0] head_q;
    logic              head_v_q;
    logic              head_we;
    logic [LINK_W-1:0] head_wdata;

    logic [IDX_W-1:0] stack_mem [NODES];
    logic [IDX_W-1:0] stack_q;
    logic             push_en;

    node_wr_t               node_wr;
    logic [KEY_W-1:0]       node_key_q;
    logic [HANDLE_BITS-1:0] node_handle_q;
    logic [LINK_W-1:0]      node_link_q;
    logic [LINK_W-1:0]      cur_head;
    logic                   accept;
    logic                   pool_empty;

    assign accept     = in_valid && in_ready;
    assign cur_head   = head_v_q ? head_q : NIL;
    assign pool_empty = (fresh_reg == NIL) && (stack_cnt_reg == '0);

    cht_node_store u_node_store (
        .clk     (clk),
        .wr      (node_wr),
        .raddr   (cur_next[IDX_W-1:0]),
        .rkey    (node_key_q),
        .rhandle (node_handle_q),
        .rlink   (node_link_q)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_q   <= head_mem[order_key[BKT_W-1:0]];
            head_v_q <= head_valid_reg[order_key[BKT_W-1:0]];
            stack_q  <= stack_mem[IDX_W'(stack_cnt_reg - LINK_W'(1))];
        end
        if (head_we)
        begin
            head_mem[key_reg[BKT_W-1:0]] <= head_wdata;
        end
        if (push_en)
        begin
            stack_mem[stack_cnt_reg[IDX_W-1:0]] <= cur_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= '0;
        end
        else if (head_we)
        begin
            head_valid_reg[key_reg[BKT_W-1:0]] <= 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (kind_reg == OP_INSERT)
                begin
                    state_next = (pool_empty || cur_head == NIL) ? S_OUT : S_NODE;
                end
                else if (kind_reg == OP_FIND || kind_reg == OP_DELETE)
                begin
                    state_next = (cur_head == NIL) ? S_OUT : S_NODE;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_NODE:
            begin
                if (node_link_q == NIL)
                begin
                    state_next = S_OUT;
                end
                else if (kind_reg == OP_FIND && node_key_q == key_reg)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        new_next       = new_reg;
        fresh_next     = fresh_reg;
        stack_cnt_next = stack_cnt_reg;
        entry_next     = entry_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        head_we        = 1'b0;
        head_wdata     = NIL;
        push_en        = 1'b0;
        node_wr        = '0;
        node_wr.wkey    = key_reg;
        node_wr.whandle = handle_reg;
        node_wr.wlink   = NIL;
        unique case (state_reg)
            S_IDLE:
            begin
                removed_next = '0;
                status_next  = ST_OK;
                found_next   = '0;
                prev_next    = NIL;
            end
            S_HEAD:
            begin
                cur_next = cur_head;
                if (kind_reg == OP_INSERT)
                begin
                    if (pool_empty)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        if (stack_cnt_reg != '0)
                        begin
                            new_next       = stack_q;
                            stack_cnt_next = stack_cnt_reg - LINK_W'(1);
                        end
                        else
                        begin
                            new_next   = fresh_reg[IDX_W-1:0];
                            fresh_next = fresh_reg + LINK_W'(1);
                        end
                        node_wr.we_full = 1'b1;
                        node_wr.waddr   = new_next;
                        entry_next      = entry_reg + CNT_W'(1);
                        if (cur_head == NIL)
                        begin
                            head_we    = 1'b1;
                            head_wdata = {1'b0, new_next};
                        end
                    end
                end
                else if ((kind_reg == OP_FIND || kind_reg == OP_DELETE) && cur_head == NIL)
                begin
                    status_next = ST_MISS;
                end
            end
            S_NODE:
            begin
                if (kind_reg == OP_INSERT)
                begin
                    if (node_link_q == NIL)
                    begin
                        node_wr.we_link = 1'b1;
                        node_wr.waddr   = cur_reg[IDX_W-1:0];
                        node_wr.wlink   = {1'b0, new_reg};
                    end
                    else
                    begin
                        cur_next = node_link_q;
                    end
                end
                else if (kind_reg == OP_FIND)
                begin
                    if (node_key_q == key_reg)
                    begin
                        found_next = node_handle_q;
                    end
                    else
                    begin
                        cur_next = node_link_q;
                        if (node_link_q == NIL)
                        begin
                            status_next = ST_MISS;
                        end
                    end
                end
                else
                begin
                    cur_next = node_link_q;
                    if (node_key_q == key_reg)
                    begin
                        if (prev_reg != NIL)
                        begin
                            node_wr.we_link = 1'b1;
                            node_wr.waddr   = prev_reg[IDX_W-1:0];
                            node_wr.wlink   = node_link_q;
                        end
                        else
                        begin
                            head_we    = 1'b1;
                            head_wdata = node_link_q;
                        end
                        push_en        = 1'b1;
                        stack_cnt_next = stack_cnt_reg + LINK_W'(1);
                        entry_next     = entry_reg - CNT_W'(1);
                        removed_next   = removed_reg + CNT_W'(1);
                    end
                    else
                    begin
                        prev_next = cur_reg;
                    end
                    if (node_link_q == NIL && (node_key_q != key_reg) && removed_reg == '0)
                    begin
                        status_next = ST_MISS;
                    end
                end
            end
            S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fresh_reg     <= '0;
            stack_cnt_reg <= '0;
            entry_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fresh_reg     <= fresh_next;
            stack_cnt_reg <= stack_cnt_next;
            entry_reg     <= entry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind;
            key_reg    <= order_key;
            handle_reg <= data_handle;
        end
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        new_reg     <= new_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign status        = status_reg;
    assign found_handle  = found_reg;
    assign removed_count = removed_reg;
    assign entry_total   = entry_reg;

`ifndef SYNTHESIS
    // Every node is either held by a chain, on the free stack or not yet used.
    assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W+1)'(entry_reg) + (CNT_W+1)'(stack_cnt_reg) + (CNT_W+1)'(NIL - fresh_reg)
            == (CNT_W+1)'(NODES))
        else $error("node accounting broken");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output sides open together");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (kind_reg == OP_INSERT))
        else $error("pool full reported for an operation other than insert");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && removed_count != '0) |-> (kind_reg == OP_DELETE && status == ST_OK))
        else $error("removal count outside a successful delete");
`endif

endmodule

>>> dv/chained_hash_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash table checker
// Watches both channels of the engine, keeps its own table of chained buckets
// and compares every result word with the oldest expected one.
// ----------------------------------------------------------------------------
module chained_hash_table_checker
    import cht_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [1:0]             kind,
    input  logic [KEY_W-1:0]       order_key,
    input  logic [HANDLE_BITS-1:0] data_handle,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [1:0]             status,
    input  logic [HANDLE_BITS-1:0] found_handle,
    input  logic [CNT_W-1:0]       removed_count,
    input  logic [CNT_W-1:0]       entry_total,
    output int                     fail_count,
    output int                     pending_count
);

    typedef struct packed {
        logic [1:0]             status;
        logic [HANDLE_BITS-1:0] handle;
        logic [CNT_W-1:0]       removed;
        logic [CNT_W-1:0]       total;
    } answer_t;

    // Each bucket is kept as an ordered list of entries, oldest first.
    typedef struct packed {
        logic [KEY_W-1:0]       key;
        logic [HANDLE_BITS-1:0] handle;
    } entry_t;

    entry_t  chain_q[BUCKETS][$];
    answer_t answer_q[$];
    int      held;

    function automatic answer_t apply_op(logic [1:0] op, logic [KEY_W-1:0] key,
                                         logic [HANDLE_BITS-1:0] hnd);
        answer_t a;
        int      b;
        entry_t  e;
        int      i;
        a = '0;
        b = int'(key % BUCKETS);
        if (op == OP_INSERT)
        begin
            if (held >= NODES)
            begin
                a.status = ST_FULL;
            end
            else
            begin
                e.key = key;
                e.handle = hnd;
                chain_q[b].push_back(e);
                held++;
            end
        end
        else if (op == OP_FIND)
        begin
            a.status = ST_MISS;
            for (i = 0; i < chain_q[b].size(); i++)
            begin
                if (chain_q[b][i].key == key)
                begin
                    a.status = ST_OK;
                    a.handle = chain_q[b][i].handle;
                    break;
                end
            end
        end
        else if (op == OP_DELETE)
        begin
            for (i = chain_q[b].size() - 1; i >= 0; i--)
            begin
                if (chain_q[b][i].key == key)
                begin
                    chain_q[b].delete(i);
                    a.removed++;
                    held--;
                end
            end
            if (a.removed == 0)
                a.status = ST_MISS;
        end
        a.total = CNT_W'(held);
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        answer_t got;
        if (!rst_n)
        begin
            fail_count <= 0;
            held = 0;
            answer_q.delete();
            for (int i = 0; i < BUCKETS; i++)
                chain_q[i].delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{status, found_handle, removed_count, entry_total};
                if (answer_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result word %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (want !== got)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("mismatch: expected st=%0d h=%h rm=%0d tot=%0d",
                                     want.status, want.handle, want.removed, want.total);
                            $display("          actual   st=%0d h=%h rm=%0d tot=%0d",
                                     got.status, got.handle, got.removed, got.total);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                answer_q.push_back(apply_op(kind, order_key, data_handle));
        end
    end

    assign pending_count = answer_q.size();

endmodule

>>> dv/tb_chained_hash_table_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash table engine testbench
// Drives directed and random insert, find, delete and no-op words under varied
// idling on both sides, including a long output hold-off; a separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_chained_hash_table_engine_top;
    import cht_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             kind;
    logic [KEY_W-1:0]       order_key;
    logic [HANDLE_BITS-1:0] data_handle;
    logic                   out_valid;
    logic                   out_ready;
    logic [1:0]             status;
    logic [HANDLE_BITS-1:0] found_handle;
    logic [CNT_W-1:0]       removed_count;
    logic [CNT_W-1:0]       entry_total;
    int                     fail_count;
    int                     pending_count;
    int                     send_idle_pct;
    int                     recv_stall_pct;
    int                     phase_num = 0;
    int                     hold_off;
    int                     quiet_cycles = 0;
    logic [KEY_W-1:0]       key_pool[16];

    chained_hash_table_engine_top u_top (.*);
    chained_hash_table_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The receiver holds off once for a long stretch in the last random phase.
    initial
    begin
        bit long_done;
        out_ready = 1'b0;
        hold_off = 0;
        long_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!long_done && phase_num == 4)
            begin
                hold_off = 300;
                long_done = 1'b1;
            end
            if (hold_off > 0)
            begin
                out_ready <= 1'b0;
                hold_off = hold_off - 1;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] op, logic [KEY_W-1:0] key,
                             logic [HANDLE_BITS-1:0] hnd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= op;
        order_key <= key;
        data_handle <= hnd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(9))
            0: k = {$urandom, $urandom};
            1: k = {$urandom, $urandom} & ~64'hFF;
            default: k = key_pool[$urandom_range(15)];
        endcase
        return k;
    endfunction

    initial
    begin
        in_valid = 1'b0;
        kind = OP_INSERT;
        order_key = '0;
        data_handle = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 16; i++)
            key_pool[i] = {$urandom, 24'($urandom_range(3)), 8'($urandom_range(3))};
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(OP_FIND, 64'd0, 32'd0);
        send_word(OP_DELETE, 64'd0, 32'd0);
        send_word(OP_INSERT, 64'd0, 32'd0);
        send_word(OP_INSERT, '1, '1);
        send_word(OP_INSERT, 64'd256, 32'h1);
        send_word(OP_INSERT, 64'd0, 32'h2);
        send_word(OP_INSERT, 64'd512, 32'hA5A5_5A5A);
        send_word(OP_FIND, 64'd0, 32'd0);
        send_word(OP_FIND, 64'd256, 32'd0);
        send_word(OP_FIND, '1, 32'd0);
        send_word(OP_FIND, 64'd768, 32'd0);
        send_word(OP_DELETE, 64'd0, 32'd0);
        send_word(OP_FIND, 64'd0, '1);
        send_word(OP_DELETE, 64'd512, 32'd0);
        send_word(OP_NONE, 64'h5555_AAAA_5555_AAAA, 32'h5555_AAAA);
        send_word(OP_FIND, 64'd256, 32'd0);
        send_word(OP_DELETE, '1, 32'd0);
        send_word(OP_DELETE, 64'd256, 32'd0);

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 72;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 72;
                end
                3:
                begin
                    send_idle_pct = 23;
                    recv_stall_pct = 23;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            phase_num = phase;
            for (int n = 0; n < 90; n++)
            begin
                logic [1:0] op;
                int         r;
                r = $urandom_range(99);
                op = (r < 45) ? OP_INSERT : (r < 75) ? OP_FIND :
                     (r < 97) ? OP_DELETE : OP_NONE;
                send_word(op, pick_key(), $urandom);
            end
        end

        // Clear out every pooled key, then look for one of them again.
        send_idle_pct = 0;
        recv_stall_pct = 10;
        for (int n = 0; n < 16; n++)
            send_word(OP_DELETE, key_pool[n], 32'd0);
        send_word(OP_FIND, key_pool[0], 32'd0);
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cht_pkg.sv
rtl/cht_node_store.sv
rtl/chained_hash_table_engine_top.sv
dv/chained_hash_table_checker.sv
dv/tb_chained_hash_table_engine_top.sv
